[hdl/ttip_pkg.sv]
`default_nettype none

package ttip_pkg;

   // field widths fixed by the interface
   localparam int BASE_WIDTH   = 6;
   localparam int BYTE_WIDTH   = 8;
   localparam int OFFSET_WIDTH = 16;
   localparam int RESULT_WIDTH = 64;

   // defaults for the top-level parameters
   localparam int          DEF_VALUE_WIDTH = 64;
   localparam int unsigned DEF_MAX_OFFSET  = 65535;

   // base register reset and special bases
   localparam logic [BASE_WIDTH-1:0] BASE_RESET  = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_DETECT = 6'd0;
   localparam logic [BASE_WIDTH-1:0] BASE_OCT    = 6'd8;
   localparam logic [BASE_WIDTH-1:0] BASE_DEC    = 6'd10;
   localparam logic [BASE_WIDTH-1:0] BASE_HEX    = 6'd16;
   localparam logic [BASE_WIDTH-1:0] BASE_MAX    = 6'd36;

   // parse phases
   localparam logic [2:0] PH_SPACE  = 3'd0;
   localparam logic [2:0] PH_FIRST  = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_DIGITS = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   // characters
   localparam logic [BYTE_WIDTH-1:0] CH_NUL   = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] CH_TAB   = 8'h09;
   localparam logic [BYTE_WIDTH-1:0] CH_LF    = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] CH_SPACE = 8'h20;
   localparam logic [BYTE_WIDTH-1:0] CH_PLUS  = 8'h2B;
   localparam logic [BYTE_WIDTH-1:0] CH_MINUS = 8'h2D;
   localparam logic [BYTE_WIDTH-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_WIDTH-1:0] CH_UP_A  = 8'h41;
   localparam logic [BYTE_WIDTH-1:0] CH_UP_X  = 8'h58;
   localparam logic [BYTE_WIDTH-1:0] CH_UP_Z  = 8'h5A;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_A  = 8'h61;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_X  = 8'h78;
   localparam logic [BYTE_WIDTH-1:0] CH_LO_Z  = 8'h7A;

   localparam logic [BYTE_WIDTH-1:0] NO_DIGIT = 8'hFF;
   localparam logic [BYTE_WIDTH-1:0] LETTER_BIAS = 8'd10;

   typedef struct packed {
      logic signed [RESULT_WIDTH-1:0] parsed_value;
      logic [OFFSET_WIDTH-1:0]        end_offset;
      logic [BASE_WIDTH-1:0]          base_used;
      logic                           overflow;
   } rsp_type;

   // digit value of a character, NO_DIGIT when it is no digit at all
   function automatic logic [BYTE_WIDTH-1:0] digit_of(input logic [BYTE_WIDTH-1:0] c);
      logic [BYTE_WIDTH-1:0] d;
      begin
         if (c >= CH_ZERO && c <= CH_NINE) begin
            d = c - CH_ZERO;
         end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            d = c - CH_LO_A + LETTER_BIAS;
         end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            d = c - CH_UP_A + LETTER_BIAS;
         end else begin
            d = NO_DIGIT;
         end
         return d;
      end
   endfunction

endpackage

`default_nettype wire

[hdl/text_to_integer_parser.sv]
`default_nettype none

// Streaming strtol-style parser. Text arrives one byte per word on the req_
// channel and is taken at one word per cycle: each byte updates the parse
// registers through one 6-bit by VALUE_WIDTH multiply-add and an overflow
// compare, so the accumulator loop sets the rate at one byte per cycle.
// Leading space, tab and newline are skipped, one sign is taken, then the
// base comes from csr_wr_data (0 detects it from a 0x/0X or 0 prefix, 16
// skips an optional 0x prefix, values above 36 act as 36). The first byte
// that is no digit of the base yields one registered word on the rsp_ channel:
// the value wrapped to VALUE_WIDTH bits and sign-extended, the count
// of bytes consumed (saturating at MAX_OFFSET), the base applied and a
// sticky overflow flag. Bytes after that are dropped up to the NUL, which
// starts a new parse; a NUL that itself stops the parse restarts at once.
// The result register is backed by a skid register, so input keeps flowing
// while one result waits; req_stall rises only when both are full. Write
// the base only while the block is idle.
module text_to_integer_parser #(
   parameter int          VALUE_WIDTH = ttip_pkg::DEF_VALUE_WIDTH,
   parameter int unsigned MAX_OFFSET  = ttip_pkg::DEF_MAX_OFFSET
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire  [ttip_pkg::BASE_WIDTH-1:0]       csr_wr_data,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [ttip_pkg::BYTE_WIDTH-1:0]       req_text_byte,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [ttip_pkg::RESULT_WIDTH-1:0] rsp_parsed_value,
   output logic [ttip_pkg::OFFSET_WIDTH-1:0]     rsp_end_offset,
   output logic [ttip_pkg::BASE_WIDTH-1:0]       rsp_base_used,
   output logic                                  rsp_overflow
);

   localparam int BW    = ttip_pkg::BASE_WIDTH;
   localparam int OW    = ttip_pkg::OFFSET_WIDTH;
   localparam int POS_W = $clog2(64'(MAX_OFFSET) + 64'd1);
   localparam int PW    = VALUE_WIDTH + BW + 1;
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_OFFSET);
   // largest positive magnitude; a negative value may go one further
   localparam logic [PW-1:0] LIM_POS = (PW'(1) << (VALUE_WIDTH - 1)) - PW'(1);

   // base register
   logic [BW-1:0] csr_base_ff;

   // parse state
   logic [2:0]             ph_ff, ph_in;
   logic                   neg_ff, neg_in;
   logic [BW-1:0]          base_ff, base_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic                   ovf_ff, ovf_in;

   // result register and skid
   logic                rsp_valid_ff;
   ttip_pkg::rsp_type   rsp_data_ff;
   logic                skid_valid_ff;
   ttip_pkg::rsp_type   skid_data_ff;

   logic                    req_accept;
   logic                    rsp_pop;
   logic                    emit;
   logic                    step;
   logic                    clear;
   logic                    fall_first;
   logic                    fall_digits;
   logic [BW-1:0]           base_sat;
   logic [7:0]              digit;
   logic [PW-1:0]           prod;
   logic [PW-1:0]           lim;
   logic signed [VALUE_WIDTH-1:0] val_s;
   logic [POS_W+OW-1:0]     pos_ext;
   ttip_pkg::rsp_type       result;

   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign rsp_pop    = rsp_valid_ff && !rsp_stall;

   assign base_sat = (csr_base_ff > ttip_pkg::BASE_MAX) ? ttip_pkg::BASE_MAX : csr_base_ff;
   assign digit    = ttip_pkg::digit_of(req_text_byte);
   assign lim      = LIM_POS + PW'(neg_ff);

   // result fields come from the state held before this byte
   assign val_s   = neg_ff ? -acc_ff : acc_ff;
   assign pos_ext = {{OW{1'b0}}, pos_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_base_ff <= ttip_pkg::BASE_RESET;
      end else if (csr_wr_en) begin
         csr_base_ff <= csr_wr_data;
      end
   end

   // One byte walks the phases it falls through within this cycle:
   // whitespace, sign, base prefix, then at most one digit or the stop.
   always_comb begin
      ph_in       = ph_ff;
      neg_in      = neg_ff;
      base_in     = base_ff;
      acc_in      = acc_ff;
      pos_in      = pos_ff;
      ovf_in      = ovf_ff;
      emit        = 1'b0;
      step        = 1'b0;
      clear       = 1'b0;
      fall_first  = 1'b0;
      fall_digits = 1'b0;
      prod        = '0;
      result.parsed_value = ttip_pkg::RESULT_WIDTH'(val_s);
      result.end_offset   = pos_ext[OW-1:0];
      result.base_used    = base_ff;
      result.overflow     = ovf_ff;

      if (req_accept) begin
         case (ph_ff)
            ttip_pkg::PH_SPACE: begin
               if (req_text_byte == ttip_pkg::CH_SPACE || req_text_byte == ttip_pkg::CH_TAB ||
                   req_text_byte == ttip_pkg::CH_LF) begin
                  step = 1'b1;
               end else if (req_text_byte == ttip_pkg::CH_MINUS ||
                            req_text_byte == ttip_pkg::CH_PLUS) begin
                  neg_in = (req_text_byte == ttip_pkg::CH_MINUS);
                  step   = 1'b1;
                  ph_in  = ttip_pkg::PH_FIRST;
               end else begin
                  fall_first = 1'b1;
               end
            end
            ttip_pkg::PH_FIRST: begin
               fall_first = 1'b1;
            end
            ttip_pkg::PH_ZERO: begin
               if (req_text_byte == ttip_pkg::CH_LO_X || req_text_byte == ttip_pkg::CH_UP_X) begin
                  base_in = ttip_pkg::BASE_HEX;
                  step    = 1'b1;
                  ph_in   = ttip_pkg::PH_DIGITS;
               end else begin
                  if (base_ff == ttip_pkg::BASE_DETECT) begin
                     base_in = ttip_pkg::BASE_OCT;
                  end
                  fall_digits = 1'b1;
               end
            end
            ttip_pkg::PH_DIGITS: begin
               fall_digits = 1'b1;
            end
            ttip_pkg::PH_DONE: begin
               clear = (req_text_byte == ttip_pkg::CH_NUL);
            end
            default: begin
               clear = 1'b1;
            end
         endcase

         // latch the base on the first byte after whitespace and sign
         if (fall_first) begin
            if ((base_sat == ttip_pkg::BASE_DETECT || base_sat == ttip_pkg::BASE_HEX) &&
                req_text_byte == ttip_pkg::CH_ZERO) begin
               base_in = base_sat;
               step    = 1'b1;
               ph_in   = ttip_pkg::PH_ZERO;
            end else begin
               base_in = (base_sat == ttip_pkg::BASE_DETECT) ? ttip_pkg::BASE_DEC : base_sat;
               fall_digits = 1'b1;
            end
         end

         if (fall_digits) begin
            ph_in = ttip_pkg::PH_DIGITS;
            prod  = PW'(acc_ff) * PW'(base_in) + PW'(digit);
            if (digit < 8'(base_in)) begin
               acc_in = prod[VALUE_WIDTH-1:0];
               ovf_in = ovf_ff || (prod > lim);
               step   = 1'b1;
            end else begin
               emit             = 1'b1;
               result.base_used = base_in;
               if (req_text_byte == ttip_pkg::CH_NUL) begin
                  clear = 1'b1;
               end else begin
                  ph_in = ttip_pkg::PH_DONE;
               end
            end
         end

         if (step && pos_ff < POS_MAX) begin
            pos_in = pos_ff + POS_W'(1);
         end

         if (clear) begin
            ph_in   = ttip_pkg::PH_SPACE;
            neg_in  = 1'b0;
            base_in = '0;
            acc_in  = '0;
            pos_in  = '0;
            ovf_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff   <= ttip_pkg::PH_SPACE;
         neg_ff  <= 1'b0;
         base_ff <= '0;
         acc_ff  <= '0;
         pos_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else begin
         ph_ff   <= ph_in;
         neg_ff  <= neg_in;
         base_ff <= base_in;
         acc_ff  <= acc_in;
         pos_ff  <= pos_in;
         ovf_ff  <= ovf_in;
      end
   end

   // Output side: a result word goes to the result register when it is
   // free or draining, else it parks in the skid register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (rsp_pop) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (!rsp_valid_ff || rsp_pop) begin
            rsp_valid_ff <= emit;
         end else if (emit) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_pop) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (!rsp_valid_ff || rsp_pop) begin
         if (emit) begin
            rsp_data_ff <= result;
         end
      end else if (emit) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_parsed_value = rsp_data_ff.parsed_value;
   assign rsp_end_offset   = rsp_data_ff.end_offset;
   assign rsp_base_used    = rsp_data_ff.base_used;
   assign rsp_overflow     = rsp_data_ff.overflow;

   // the skid register is only ever filled behind a held result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while result register empty");

   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_MAX)
      else $error("byte position beyond its saturation point");

   a_nul_restarts: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_text_byte == ttip_pkg::CH_NUL) |=>
         (ph_ff == ttip_pkg::PH_SPACE && pos_ff == '0 && acc_ff == '0))
      else $error("end of text did not restart the parse");

   a_base_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.base_used != ttip_pkg::BASE_DETECT))
      else $error("result word carries no resolved base");

   a_emit_leaves_digits: assert property (@(posedge clock) disable iff (reset)
      emit |=> (ph_ff == ttip_pkg::PH_DONE || ph_ff == ttip_pkg::PH_SPACE))
      else $error("parse kept going after a result");

endmodule

`default_nettype wire

[tb/sv/tb_text_to_integer_parser.sv]
`timescale 1ns / 100ps

module tb_text_to_integer_parser;

   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          LONG_HOLD     = 400;
   localparam int          SETTLE_CYCLES = 4;
   localparam int          RANDOM_PHASES = 12;
   localparam int          PHASE_BYTES   = 170;
   localparam logic [63:0] VALUE_MASK    = {64{1'b1}} >> (64 - ttip_pkg::DEF_VALUE_WIDTH);
   localparam logic [ttip_pkg::BASE_WIDTH-1:0] BASE_ONE = 6'd1;
   localparam logic [ttip_pkg::BASE_WIDTH-1:0] BASE_BIN = 6'd2;
   localparam logic [ttip_pkg::BASE_WIDTH-1:0] BASE_TOP = 6'd63;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                    csr_wr_en     = 1'b0;
   logic [ttip_pkg::BASE_WIDTH-1:0]         csr_wr_data   = '0;
   logic                                    req_valid     = 1'b0;
   logic                                    req_stall;
   logic [ttip_pkg::BYTE_WIDTH-1:0]         req_text_byte = '0;
   logic                                    rsp_valid;
   logic                                    rsp_stall     = 1'b0;
   logic signed [ttip_pkg::RESULT_WIDTH-1:0] rsp_parsed_value;
   logic [ttip_pkg::OFFSET_WIDTH-1:0]       rsp_end_offset;
   logic [ttip_pkg::BASE_WIDTH-1:0]         rsp_base_used;
   logic                                    rsp_overflow;

   // text bytes waiting to be offered, oldest first
   logic [ttip_pkg::BYTE_WIDTH-1:0] text_fifo [$];
   int unsigned                     bytes_queued = 0;
   // parse results the block owes us, oldest first
   ttip_pkg::rsp_type               parse_results_due [$];

   // shadow copy of the parser state and its base register
   logic [ttip_pkg::BASE_WIDTH-1:0]   base_copy;
   logic [2:0]                        ps_phase;
   bit                                ps_neg;
   logic [ttip_pkg::BASE_WIDTH-1:0]   ps_base;
   logic [63:0]                       ps_acc;
   logic [ttip_pkg::OFFSET_WIDTH-1:0] ps_pos;
   bit                                ps_ovf;

   logic        req_took = 1'b0;
   int unsigned send_gap = 0;
   int unsigned send_calm = 0;
   int unsigned hold_left = 0;
   int unsigned stall_calm = 0;
   bit          long_hold_request = 1'b0;
   bit          long_hold_done = 1'b0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   string limit_texts [4] = '{"9223372036854775807", "9223372036854775808",
                              "9223372036854775809", "18446744073709551616"};

   logic [ttip_pkg::BASE_WIDTH-1:0] base_plan [8] = '{
      ttip_pkg::BASE_DETECT, ttip_pkg::BASE_DEC, ttip_pkg::BASE_HEX, ttip_pkg::BASE_MAX,
      BASE_TOP, BASE_ONE, BASE_BIN, ttip_pkg::BASE_OCT};

   text_to_integer_parser u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_text_byte    (req_text_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_parsed_value (rsp_parsed_value),
      .rsp_end_offset   (rsp_end_offset),
      .rsp_base_used    (rsp_base_used),
      .rsp_overflow     (rsp_overflow)
   );

   always #5 clock = ~clock;

   // Weight of a character as a digit; 255 marks a character that is no digit.
   function automatic logic [7:0] char_weight(input logic [7:0] c);
      if (c >= ttip_pkg::CH_ZERO && c <= ttip_pkg::CH_NINE) return c - ttip_pkg::CH_ZERO;
      if (c >= ttip_pkg::CH_LO_A && c <= ttip_pkg::CH_LO_Z)
         return c - ttip_pkg::CH_LO_A + 8'd10;
      if (c >= ttip_pkg::CH_UP_A && c <= ttip_pkg::CH_UP_Z)
         return c - ttip_pkg::CH_UP_A + 8'd10;
      return 8'hFF;
   endfunction

   function automatic void clear_parse();
      ps_phase = ttip_pkg::PH_SPACE;
      ps_neg   = 1'b0;
      ps_base  = '0;
      ps_acc   = '0;
      ps_pos   = '0;
      ps_ovf   = 1'b0;
   endfunction

   // Advance the consumed-byte count, saturating at the top offset.
   function automatic void bump_position();
      if (ps_pos < 16'(ttip_pkg::DEF_MAX_OFFSET)) ps_pos++;
   endfunction

   // Run one accepted text byte through the shadow parser. A byte may fall
   // through several phases before it is consumed; a stop byte queues one
   // expected result.
   task automatic parse_byte(input logic [7:0] c);
      logic [ttip_pkg::BASE_WIDTH-1:0] b;
      logic [7:0]                      d;
      logic [63:0]                     lim;
      logic [63:0]                     v;
      ttip_pkg::rsp_type               r;
      bit                              more;
      more = 1'b1;
      while (more) begin
         more = 1'b0;
         case (ps_phase)
            ttip_pkg::PH_SPACE: begin
               if (c == ttip_pkg::CH_SPACE || c == ttip_pkg::CH_TAB ||
                   c == ttip_pkg::CH_LF) begin
                  bump_position();
               end else if (c == ttip_pkg::CH_MINUS || c == ttip_pkg::CH_PLUS) begin
                  ps_neg   = (c == ttip_pkg::CH_MINUS);
                  bump_position();
                  ps_phase = ttip_pkg::PH_FIRST;
               end else begin
                  ps_phase = ttip_pkg::PH_FIRST;
                  more     = 1'b1;
               end
            end
            ttip_pkg::PH_FIRST: begin
               // latch the base here; later register writes wait for the next text
               b = (base_copy > ttip_pkg::BASE_MAX) ? ttip_pkg::BASE_MAX : base_copy;
               if ((b == ttip_pkg::BASE_DETECT || b == ttip_pkg::BASE_HEX) &&
                   c == ttip_pkg::CH_ZERO) begin
                  ps_base  = b;
                  bump_position();
                  ps_phase = ttip_pkg::PH_ZERO;
               end else begin
                  ps_base  = (b == ttip_pkg::BASE_DETECT) ? ttip_pkg::BASE_DEC : b;
                  ps_phase = ttip_pkg::PH_DIGITS;
                  more     = 1'b1;
               end
            end
            ttip_pkg::PH_ZERO: begin
               if (c == ttip_pkg::CH_LO_X || c == ttip_pkg::CH_UP_X) begin
                  ps_base  = ttip_pkg::BASE_HEX;
                  bump_position();
                  ps_phase = ttip_pkg::PH_DIGITS;
               end else begin
                  if (ps_base == ttip_pkg::BASE_DETECT) ps_base = ttip_pkg::BASE_OCT;
                  ps_phase = ttip_pkg::PH_DIGITS;
                  more     = 1'b1;
               end
            end
            ttip_pkg::PH_DIGITS: begin
               d = char_weight(c);
               if (d < 8'(ps_base)) begin
                  lim = (VALUE_MASK >> 1) + 64'(ps_neg);
                  if (!ps_ovf && ps_acc > (lim - 64'(d)) / 64'(ps_base)) ps_ovf = 1'b1;
                  ps_acc = (ps_acc * 64'(ps_base) + 64'(d)) & VALUE_MASK;
                  bump_position();
               end else begin
                  v = ps_neg ? ((64'd0 - ps_acc) & VALUE_MASK) : ps_acc;
                  if (v[ttip_pkg::DEF_VALUE_WIDTH-1]) v = v | ~VALUE_MASK;
                  r.parsed_value = v;
                  r.end_offset   = ps_pos;
                  r.base_used    = ps_base;
                  r.overflow     = ps_ovf;
                  parse_results_due.push_back(r);
                  if (c == ttip_pkg::CH_NUL) clear_parse();
                  else ps_phase = ttip_pkg::PH_DONE;
               end
            end
            ttip_pkg::PH_DONE: begin
               if (c == ttip_pkg::CH_NUL) clear_parse();
            end
            default: begin
               clear_parse();
               more = 1'b1;
            end
         endcase
      end
   endtask

   // Pick an idle length: mostly none or short, now and then long, and
   // sometimes open a calm stretch with no idling at all.
   function automatic int unsigned idle_length(inout int unsigned calm);
      int unsigned r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 40) == 0) calm = $urandom_range(20, 80);
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Sample both handshakes at the rising edge: predict from every accepted
   // text word, shadow the base register and check every accepted result word.
   always @(posedge clock) begin : check_words
      ttip_pkg::rsp_type got;
      ttip_pkg::rsp_type want;
      if (reset) begin
         req_took  <= 1'b0;
         base_copy = ttip_pkg::BASE_RESET;
         clear_parse();
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && !req_stall) parse_byte(req_text_byte);
         if (csr_wr_en) base_copy = csr_wr_data;
         if (rsp_valid && !rsp_stall) begin
            got.parsed_value = rsp_parsed_value;
            got.end_offset   = rsp_end_offset;
            got.base_used    = rsp_base_used;
            got.overflow     = rsp_overflow;
            if (parse_results_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: value %0d offset %0d base %0d ovf %0b",
                           got.parsed_value, got.end_offset, got.base_used, got.overflow);
            end else begin
               want = parse_results_due.pop_front();
               if (got.parsed_value !== want.parsed_value ||
                   got.end_offset !== want.end_offset ||
                   got.base_used !== want.base_used ||
                   got.overflow !== want.overflow) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp/got: value %0d/%0d offset %0d/%0d %s",
                              want.parsed_value, got.parsed_value,
                              want.end_offset, got.end_offset,
                              $sformatf("base %0d/%0d ovf %0b/%0b",
                                        want.base_used, got.base_used,
                                        want.overflow, got.overflow));
               end
            end
         end
      end
   end

   // Drive text words at the falling edge. Hold a stalled word unchanged;
   // drop the front of the fifo once its word was taken, then idle or
   // present the next byte.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_took) void'(text_fifo.pop_front());
         if (!req_valid || req_took) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (text_fifo.size() != 0) begin
               req_valid     <= 1'b1;
               req_text_byte <= text_fifo[0];
               send_gap = idle_length(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Stall the result channel at random; on request hold off for one long
   // stretch so the result and skid registers fill and req_stall rises.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (long_hold_request && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         hold_left = idle_length(stall_calm);
      end
   end

   task automatic push_byte(input logic [7:0] b);
      text_fifo.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_chars(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   // Write the base register at the falling edge; only called after a drain.
   task automatic write_base(input logic [ttip_pkg::BASE_WIDTH-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Wait until every queued byte went in and every owed result came out,
   // then let the pipeline settle in case the last bytes caused no result.
   task automatic drain_phase();
      do begin
         @(posedge clock);
         #1;
      end while (text_fifo.size() != 0 || req_valid || parse_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] digit_char(input int unsigned v);
      if (v < 10) return ttip_pkg::CH_ZERO + 8'(v);
      return ($urandom_range(0, 1) ? ttip_pkg::CH_LO_A : ttip_pkg::CH_UP_A) + 8'(v - 10);
   endfunction

   function automatic logic [7:0] space_char();
      case ($urandom_range(0, 2))
         0:       return ttip_pkg::CH_SPACE;
         1:       return ttip_pkg::CH_TAB;
         default: return ttip_pkg::CH_LF;
      endcase
   endfunction

   // Queue one random text for the given register base. Most texts are well
   // formed (space, sign, prefix, digits of the base, stop byte, trailing
   // junk, NUL); a few are raw noise or carry a doubled sign.
   task automatic add_random_text(input logic [ttip_pkg::BASE_WIDTH-1:0] base_now);
      int unsigned b;
      int unsigned n;
      int unsigned r;
      b = (base_now > ttip_pkg::BASE_MAX) ? ttip_pkg::BASE_MAX : base_now;
      if ($urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(0, 255)));
         return;
      end
      repeat ($urandom_range(0, 3)) push_byte(space_char());
      r = $urandom_range(0, 7);
      if (r < 2) push_byte(ttip_pkg::CH_MINUS);
      else if (r < 4) push_byte(ttip_pkg::CH_PLUS);
      else if (r == 4) begin
         push_byte(ttip_pkg::CH_MINUS);
         push_byte(ttip_pkg::CH_PLUS);
      end
      if (b == ttip_pkg::BASE_DETECT) begin
         case ($urandom_range(0, 2))
            0: begin
               push_byte(ttip_pkg::CH_ZERO);
               push_byte($urandom_range(0, 1) ? ttip_pkg::CH_LO_X : ttip_pkg::CH_UP_X);
               b = ttip_pkg::BASE_HEX;
            end
            1: begin
               push_byte(ttip_pkg::CH_ZERO);
               b = ttip_pkg::BASE_OCT;
            end
            default: b = ttip_pkg::BASE_DEC;
         endcase
      end else if (b == ttip_pkg::BASE_HEX && $urandom_range(0, 1)) begin
         push_byte(ttip_pkg::CH_ZERO);
         push_byte($urandom_range(0, 1) ? ttip_pkg::CH_LO_X : ttip_pkg::CH_UP_X);
      end
      if (b == ttip_pkg::BASE_DEC && $urandom_range(0, 7) == 0) begin
         // walk right up to and past the signed limit
         push_chars(limit_texts[$urandom_range(0, 3)]);
      end else begin
         r = $urandom_range(0, 23);
         n = (r < 2) ? 0 : (r < 20) ? $urandom_range(1, 6) : $urandom_range(12, 24);
         repeat (n) push_byte(digit_char($urandom_range(0, b - 1)));
      end
      if ($urandom_range(0, 2) != 0) begin
         push_byte(8'($urandom_range(1, 255)));
         repeat ($urandom_range(0, 3)) push_byte(8'($urandom_range(1, 255)));
      end
      push_byte(ttip_pkg::CH_NUL);
   endtask

   initial begin : stimulus
      logic [ttip_pkg::BASE_WIDTH-1:0] next_base;
      int unsigned                     start;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      // Reset base 10: sign and a stop letter, then an all-ones byte that
      // must be dropped until the NUL.
      push_chars(" -9z");
      push_byte(8'hFF);
      push_byte(ttip_pkg::CH_NUL);
      drain_phase();

      // Detect mode: hex prefix, lone zero, sign with no digit, and a hex
      // prefix followed by no hex digit.
      write_base(ttip_pkg::BASE_DETECT);
      push_chars("0x1F");
      push_byte(ttip_pkg::CH_NUL);
      push_chars("0");
      push_byte(ttip_pkg::CH_NUL);
      push_chars("\n+");
      push_byte(ttip_pkg::CH_NUL);
      push_chars("0xg");
      push_byte(ttip_pkg::CH_NUL);
      drain_phase();

      // Base 1 takes only zero. Then leave a parse waiting after its sign,
      // switch to an out-of-range base (acts as 36) before the base latches,
      // and switch again once digits are in: the latched base must hold.
      write_base(BASE_ONE);
      push_chars("01");
      push_byte(ttip_pkg::CH_NUL);
      push_byte(ttip_pkg::CH_MINUS);
      drain_phase();
      write_base(BASE_TOP);
      push_chars("Zz7");
      drain_phase();
      write_base(BASE_BIN);
      push_chars("9");
      push_byte(ttip_pkg::CH_NUL);
      drain_phase();

      // Random phases, each under its own base setting.
      for (int k = 0; k < RANDOM_PHASES; k++) begin
         next_base = (k < 8) ? base_plan[k] : ttip_pkg::BASE_WIDTH'($urandom_range(0, 63));
         write_base(next_base);
         start = bytes_queued;
         while (bytes_queued - start < PHASE_BYTES) add_random_text(next_base);
         if (k == 1) long_hold_request = 1'b1;
         drain_phase();
      end

      if (parse_results_due.size() != 0) begin
         fail_count++;
         $display("%0d result words never arrived", parse_results_due.size());
      end
      if (fail_count == 0) begin
         $display("** text_to_integer_parser: PASSED **");
      end else begin
         $display("** text_to_integer_parser: FAILED **");
      end
      $finish;
   end

   // Watchdog: end the run if it has not finished by the cycle limit.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** text_to_integer_parser: FAILED **");
      $finish;
   end

endmodule

[sim.f]
hdl/ttip_pkg.sv
hdl/text_to_integer_parser.sv
tb/sv/tb_text_to_integer_parser.sv
